### design/slps_pkg.sv
// ----------------------------------------------------------------------------
// slps_pkg
// Constants shared by the signed logarithmic pixel scale unit.
// ----------------------------------------------------------------------------
`default_nettype none

package slps_pkg;

	// width of the scale register (signed fixed point)
	localparam int unsigned SCALE_BITS = 16;

	// mantissa is unsigned Q30 during the log2 squaring chain
	localparam int unsigned MANT_FRAC = 30;
	localparam int unsigned MANT_BITS = MANT_FRAC + 1;

	// ln(2) rounded to Q32
	localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

	// scale reset value is 10.0 before placement at the fraction point
	localparam logic [31:0] SCALE_RESET_INT = 32'd10;

endpackage : slps_pkg

`default_nettype wire

### design/signed_log_pixel_scale_unit.sv
// From an accepted start, a pixel passes the magnitude, leading-one, normalise,
// squaring-chain, ln, scale and output registers before its done strobe.
// Throughput: one pixel per clock; busy stays low and the receiver cannot stall.
// The depth is set by the log2 fraction chain, one squaring multiplier per bit.
// Reset clears all stage valid bits and loads the scale register with 10.0.
// ----------------------------------------------------------------------------
// signed_log_pixel_scale_unit
// Odd-symmetric logarithmic pixel scaling, c * ln(1 + |x|) with the sign of
// x and c applied, truncated toward zero and saturated to the pixel range.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_log_pixel_scale_unit
	import slps_pkg::*;
#(
	parameter int unsigned PIXEL_BITS      = 16,
	parameter int unsigned LOG_FRAC_BITS   = 16,
	parameter int unsigned SCALE_FRAC_BITS = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [PIXEL_BITS-1:0] pixel_in,
	output logic                              done,
	output logic signed [PIXEL_BITS-1:0]      pixel_out,
	output logic                              clipped,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic signed [SCALE_BITS-1:0] cfg_data
);

	localparam int unsigned KW  = $clog2(PIXEL_BITS);
	localparam int unsigned L2W = KW + LOG_FRAC_BITS;
	localparam int unsigned LPW = L2W + 32;
	localparam int unsigned PW  = SCALE_BITS + L2W;
	localparam int unsigned CW  = (PW > PIXEL_BITS + 1) ? PW : PIXEL_BITS + 1;
	localparam int unsigned SH  = SCALE_FRAC_BITS + LOG_FRAC_BITS;
	localparam int unsigned WW  = PIXEL_BITS + MANT_FRAC;

	localparam logic [31:0]           SCALE_FULL  = SCALE_RESET_INT << SCALE_FRAC_BITS;
	localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_FULL[SCALE_BITS-1:0];
	localparam logic [CW-1:0]         SIGN_MAG    = CW'(1) << (PIXEL_BITS - 1);
	localparam logic [CW-1:0]         POS_MAX     = SIGN_MAG - CW'(1);

	// --------------------------------------------------------------------
	// handshakes and scale register
	// --------------------------------------------------------------------
	logic [SCALE_BITS-1:0] scale_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= cfg_data;
		end
	end

	// --------------------------------------------------------------------
	// stage 1: magnitude and a = 1 + |x|
	// --------------------------------------------------------------------
	logic                  vld_s1;
	logic                  xpos_s1;
	logic [PIXEL_BITS-1:0] a_s1;
	logic [PIXEL_BITS-1:0] xmag;

	// most negative pixel wraps to 2^(P-1), which is the exact magnitude
	assign xmag = pixel_in[PIXEL_BITS-1] ? (~pixel_in + PIXEL_BITS'(1)) : pixel_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		xpos_s1 <= (pixel_in != '0) && !pixel_in[PIXEL_BITS-1];
		a_s1    <= xmag + PIXEL_BITS'(1);
	end

	// --------------------------------------------------------------------
	// stage 2: leading-one position
	// --------------------------------------------------------------------
	logic                  vld_s2;
	logic                  xpos_s2;
	logic [PIXEL_BITS-1:0] a_s2;
	logic [KW-1:0]         k_s2;
	logic [KW-1:0]         lead;

	always_comb begin
		lead = '0;
		for (int i = 0; i < PIXEL_BITS; i++) begin
			if (a_s1[i]) begin
				lead = KW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		xpos_s2 <= xpos_s1;
		a_s2    <= a_s1;
		k_s2    <= lead;
	end

	// --------------------------------------------------------------------
	// stage 3: normalise to Q30 mantissa, a * 2^30 / 2^k truncated
	// --------------------------------------------------------------------
	logic [WW-1:0] norm;

	assign norm = {a_s2, MANT_FRAC'(0)} >> k_s2;

	// squaring chain, entry 0 is the stage 3 register
	logic                     sq_vld_s  [LOG_FRAC_BITS+1];
	logic                     sq_xpos_s [LOG_FRAC_BITS+1];
	logic [KW-1:0]            sq_k_s    [LOG_FRAC_BITS+1];
	logic [MANT_BITS-1:0]     sq_mant_s [LOG_FRAC_BITS+1];
	logic [LOG_FRAC_BITS-1:0] sq_frac_s [LOG_FRAC_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s[0] <= 1'b0;
		end else begin
			sq_vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sq_xpos_s[0] <= xpos_s2;
		sq_k_s[0]    <= k_s2;
		sq_mant_s[0] <= norm[MANT_BITS-1:0];
		sq_frac_s[0] <= '0;
	end

	// --------------------------------------------------------------------
	// stages 4 .. LOG_FRAC_BITS+3: one log2 fraction bit per squaring
	// --------------------------------------------------------------------
	for (genvar g = 0; g < LOG_FRAC_BITS; g++) begin : g_sq
		logic [2*MANT_BITS-1:0] sq;
		logic [MANT_BITS:0]     t;
		logic [MANT_BITS-1:0]   nxt;

		assign sq  = sq_mant_s[g] * sq_mant_s[g];
		assign t   = sq[2*MANT_BITS-1:MANT_FRAC];
		// square reached 2.0: emit a one and halve
		assign nxt = t[MANT_BITS] ? t[MANT_BITS:1] : t[MANT_BITS-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[g+1] <= 1'b0;
			end else begin
				sq_vld_s[g+1] <= sq_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			sq_xpos_s[g+1] <= sq_xpos_s[g];
			sq_k_s[g+1]    <= sq_k_s[g];
			sq_mant_s[g+1] <= nxt;
			sq_frac_s[g+1] <= {sq_frac_s[g][LOG_FRAC_BITS-2:0], t[MANT_BITS]};
		end
	end

	// --------------------------------------------------------------------
	// ln stage: ln(a) = (log2(a) * ln2_q32) >> 32
	// --------------------------------------------------------------------
	logic           vld_ln_s;
	logic           xpos_ln_s;
	logic [L2W-1:0] ln_ln_s;
	logic [L2W-1:0] l2;
	logic [LPW-1:0] l2_prod;

	assign l2      = {sq_k_s[LOG_FRAC_BITS], sq_frac_s[LOG_FRAC_BITS]};
	assign l2_prod = l2 * LN2_Q32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_ln_s <= 1'b0;
		end else begin
			vld_ln_s <= sq_vld_s[LOG_FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		xpos_ln_s <= sq_xpos_s[LOG_FRAC_BITS];
		ln_ln_s   <= l2_prod[LPW-1:32];
	end

	// --------------------------------------------------------------------
	// scale stage: |c| * ln(a), sign resolved
	// --------------------------------------------------------------------
	logic                  vld_mul_s;
	logic                  neg_mul_s;
	logic [PW-1:0]         prod_mul_s;
	logic                  cneg;
	logic [SCALE_BITS-1:0] cmag;
	logic [PW-1:0]         sc_prod;

	assign cneg    = scale_q[SCALE_BITS-1];
	assign cmag    = cneg ? (~scale_q + SCALE_BITS'(1)) : scale_q;
	assign sc_prod = cmag * ln_ln_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_mul_s <= 1'b0;
		end else begin
			vld_mul_s <= vld_ln_s;
		end
	end

	always_ff @(posedge clk) begin
		neg_mul_s  <= (!xpos_ln_s) != cneg;
		prod_mul_s <= sc_prod;
	end

	// --------------------------------------------------------------------
	// output stage: truncate, saturate, apply sign
	// --------------------------------------------------------------------
	logic [CW-1:0]         mag;
	logic [CW-1:0]         mag_c;
	logic [PIXEL_BITS-1:0] res;
	logic                  clip;

	assign mag = CW'(prod_mul_s) >> SH;

	always_comb begin
		mag_c = mag;
		clip  = 1'b0;
		res   = '0;
		if (mag == '0) begin
			res = '0;
		end else if (neg_mul_s) begin
			if (mag > SIGN_MAG) begin
				mag_c = SIGN_MAG;
				clip  = 1'b1;
			end
			res = ~mag_c[PIXEL_BITS-1:0] + PIXEL_BITS'(1);
		end else begin
			if (mag > POS_MAX) begin
				mag_c = POS_MAX;
				clip  = 1'b1;
			end
			res = mag_c[PIXEL_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_mul_s;
		end
	end

	always_ff @(posedge clk) begin
		pixel_out <= res;
		clipped   <= clip;
	end

endmodule : signed_log_pixel_scale_unit

`default_nettype wire
